[rtl/relative_pose_transform_top_macros.svh]
// ----------------------------------------------------------------------------
// relative_pose_transform_top_macros
// assertion macros used by the port-level checker of the relative pose block
// ----------------------------------------------------------------------------
`ifndef RELATIVE_POSE_TRANSFORM_TOP_MACROS_SVH
`define RELATIVE_POSE_TRANSFORM_TOP_MACROS_SVH

// property checked at every rising clock edge outside reset
`define RPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition in one cycle implies a consequence in the next
`define RPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  `RPT_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[rtl/rpt_pkg.sv]
// ----------------------------------------------------------------------------
// rpt_pkg
// types, widths and constants of the relative pose transform
// ----------------------------------------------------------------------------
package rpt_pkg;

  // field widths
  localparam int Q_W       = 16;  // quaternion component, Q2.14
  localparam int P_W       = 32;  // position, Q16.16
  localparam int D_W       = 33;  // exact position difference
  localparam int MAT_W     = 20;  // rotation matrix entry, Q.14
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_Q    = 14;

  // shared multiply-accumulate unit
  localparam int OPA_W  = MAT_W;
  localparam int OPB_W  = D_W;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = 56;
  localparam int RND_W  = ACC_W - FRAC_Q;

  localparam logic signed [Q_W-1:0] Q_ONE       = 16'sd16384;
  localparam logic signed [Q_W-1:0] MOUNT_W_RST = 16'sd8192;
  localparam logic signed [Q_W-1:0] MOUNT_X_RST = 16'sd8192;
  localparam logic signed [Q_W-1:0] MOUNT_Y_RST = 16'sd8192;
  localparam logic signed [Q_W-1:0] MOUNT_Z_RST = -16'sd8192;

  // subtracted terms of a quaternion product, bit {component, term}
  localparam logic [15:0] QUAT_NEG = 16'h428E;

  typedef struct packed {
    logic                    mode;
    logic                    set_start;
    logic signed [P_W-1:0]   in_pos_x;
    logic signed [P_W-1:0]   in_pos_y;
    logic signed [P_W-1:0]   in_pos_z;
    logic signed [Q_W-1:0]   in_quat_w;
    logic signed [Q_W-1:0]   in_quat_x;
    logic signed [Q_W-1:0]   in_quat_y;
    logic signed [Q_W-1:0]   in_quat_z;
  } rpt_in_t;

  typedef struct packed {
    logic signed [Q_W-1:0]   mounted_quat_w;
    logic signed [Q_W-1:0]   mounted_quat_x;
    logic signed [Q_W-1:0]   mounted_quat_y;
    logic signed [Q_W-1:0]   mounted_quat_z;
    logic signed [P_W-1:0]   rel_pos_x;
    logic signed [P_W-1:0]   rel_pos_y;
    logic signed [P_W-1:0]   rel_pos_z;
    logic signed [Q_W-1:0]   rel_quat_w;
    logic signed [Q_W-1:0]   rel_quat_x;
    logic signed [Q_W-1:0]   rel_quat_y;
    logic signed [Q_W-1:0]   rel_quat_z;
  } rpt_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [Q_W-1:0]       value;
  } rpt_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOUNT,
    ST_MDRN,
    ST_CAPT,
    ST_REL,
    ST_MAT,
    ST_ROT,
    ST_RDRN,
    ST_OUT
  } rpt_state_e;

  // where a finished sum is written
  typedef enum logic [1:0] {
    DST_M,
    DST_RQ,
    DST_MAT,
    DST_RP
  } rpt_dst_e;

  typedef struct packed {
    logic     vld;
    logic     first;
    logic     one;
    logic     neg;
    logic     dbl;
    logic     last;
    rpt_dst_e dst;
    logic [3:0] idx;
  } rpt_issue_t;

  typedef struct packed {
    logic                    vld;
    rpt_dst_e                dst;
    logic [3:0]              idx;
    logic signed [RND_W-1:0] value;
  } rpt_wb_t;

  typedef struct packed {
    logic [1:0] ia;
    logic [1:0] ib;
    logic       neg;
    logic       diag;
  } rpt_mat_term_t;

  // product terms of the rotation matrix entries, components w=0 .. z=3
  function automatic rpt_mat_term_t mat_term(input logic [3:0] e, input logic t);
    rpt_mat_term_t r;
    r = '0;
    case (e)
      4'd0:    r = t ? '{2'd3, 2'd3, 1'b1, 1'b1} : '{2'd2, 2'd2, 1'b1, 1'b1};
      4'd1:    r = t ? '{2'd0, 2'd3, 1'b1, 1'b0} : '{2'd1, 2'd2, 1'b0, 1'b0};
      4'd2:    r = t ? '{2'd0, 2'd2, 1'b0, 1'b0} : '{2'd1, 2'd3, 1'b0, 1'b0};
      4'd3:    r = t ? '{2'd0, 2'd3, 1'b0, 1'b0} : '{2'd1, 2'd2, 1'b0, 1'b0};
      4'd4:    r = t ? '{2'd3, 2'd3, 1'b1, 1'b1} : '{2'd1, 2'd1, 1'b1, 1'b1};
      4'd5:    r = t ? '{2'd0, 2'd1, 1'b1, 1'b0} : '{2'd2, 2'd3, 1'b0, 1'b0};
      4'd6:    r = t ? '{2'd0, 2'd2, 1'b1, 1'b0} : '{2'd1, 2'd3, 1'b0, 1'b0};
      4'd7:    r = t ? '{2'd0, 2'd1, 1'b0, 1'b0} : '{2'd2, 2'd3, 1'b0, 1'b0};
      4'd8:    r = t ? '{2'd2, 2'd2, 1'b1, 1'b1} : '{2'd1, 2'd1, 1'b1, 1'b1};
      default: r = '0;
    endcase
    return r;
  endfunction

  // saturate a rounded sum to a quaternion component
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [RND_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if ((&v[RND_W-1:Q_W-1]) || !(|v[RND_W-1:Q_W-1])) r = v[Q_W-1:0];
    else if (v[RND_W-1]) r = {1'b1, {(Q_W-1){1'b0}}};
    else r = {1'b0, {(Q_W-1){1'b1}}};
    return r;
  endfunction

  // saturate a rounded sum to a position
  function automatic logic signed [P_W-1:0] sat_p(input logic signed [RND_W-1:0] v);
    logic signed [P_W-1:0] r;
    if ((&v[RND_W-1:P_W-1]) || !(|v[RND_W-1:P_W-1])) r = v[P_W-1:0];
    else if (v[RND_W-1]) r = {1'b1, {(P_W-1){1'b0}}};
    else r = {1'b0, {(P_W-1){1'b1}}};
    return r;
  endfunction

endpackage

[rtl/rpt_chan_if.sv]
// ----------------------------------------------------------------------------
// rpt_chan_if
// valid/ready channel carrying one payload item
// ----------------------------------------------------------------------------
interface rpt_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/relative_pose_transform_top.sv]
// ----------------------------------------------------------------------------
// relative_pose_transform_top
// mounted orientation and pose relative to a captured start pose
// ----------------------------------------------------------------------------
// pose_in_i takes one pose item (mode, set_start, position, quaternion);
// pose_out_o gives one result item per pose item; cfg_i writes the mounting
// rotation registers (index 0..3 = w, x, y, z) and is always ready.
// one multiply-accumulate unit does all the work: 16 products for the
// mounted quaternion, 16 for the relative quaternion, 18 for the rotation
// matrix of the start orientation, 9 for the rotated position, plus pipeline
// drain and capture cycles. the input is ready only while the block is idle:
// no new item is taken before the previous result is in the output register.
// the result sits in an output register: the next item is accepted and
// computed while it waits, and only the hand-over of that next result stalls
// until the receiver takes the previous one.
// reset sets the mount to its default rotation, the start pose to identity
// at the origin and marks a start capture pending for the next odometry item.
// ----------------------------------------------------------------------------
module relative_pose_transform_top import rpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rpt_chan_if.sink   pose_in_i,
  rpt_chan_if.source pose_out_o,
  rpt_chan_if.sink   cfg_i
);

  rpt_state_e state_q, state_d;
  logic [3:0] grp_q, grp_d;
  logic [1:0] term_q, term_d;
  logic       out_valid_q;
  logic       pending_q;
  logic       in_acc, load_out, cap;

  logic signed [Q_W-1:0]   mount_q [4];
  logic signed [P_W-1:0]   start_pos_q [3];
  logic signed [Q_W-1:0]   start_ori_q [4];
  logic signed [Q_W-1:0]   so_copy_q [4];
  logic                    mode_q;
  logic signed [P_W-1:0]   pos_q [3];
  logic signed [Q_W-1:0]   qin_q [4];
  logic signed [Q_W-1:0]   m_q [4];
  logic signed [Q_W-1:0]   rq_q [4];
  logic signed [MAT_W-1:0] mat_q [9];
  logic signed [D_W-1:0]   d_q [3];
  logic signed [P_W-1:0]   rp_q [3];
  rpt_out_t                out_q;

  rpt_issue_t              iss;
  logic signed [OPA_W-1:0] opa;
  logic signed [OPB_W-1:0] opb;
  rpt_wb_t                 wb;
  rpt_mat_term_t           mt;
  logic [3:0]              rot_idx;

  assign in_acc          = pose_in_i.valid && pose_in_i.ready;
  assign pose_in_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready     = 1'b1;
  assign pose_out_o.valid = out_valid_q;
  assign pose_out_o.data  = out_q;
  assign cap             = !mode_q && pending_q;

  // matrix entry (row term, column grp) for the rotated position
  assign rot_idx = 4'({term_q, 1'b0}) + 4'(term_q) + grp_q;

  // shared unit
  rpt_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .iss_i  (iss),
    .opa_i  (opa),
    .opb_i  (opb),
    .wb_o   (wb)
  );

  // sequencer: next state, counters and operand selection
  always_comb begin
    state_d  = state_q;
    grp_d    = grp_q;
    term_d   = term_q;
    iss      = '0;
    opa      = '0;
    opb      = '0;
    load_out = 1'b0;
    mt       = mat_term(grp_q, term_q[0]);
    case (state_q)
      ST_IDLE: begin
        if (pose_in_i.valid) begin
          state_d = ST_MOUNT;
          grp_d   = '0;
          term_d  = '0;
        end
      end
      // m = q_in * mount
      ST_MOUNT: begin
        iss.vld   = 1'b1;
        iss.first = (term_q == 2'd0);
        iss.last  = (term_q == 2'd3);
        iss.neg   = QUAT_NEG[{grp_q[1:0], term_q}];
        iss.dst   = DST_M;
        iss.idx   = grp_q;
        opa       = OPA_W'(qin_q[term_q]);
        opb       = OPB_W'(mount_q[grp_q[1:0] ^ term_q]);
        term_d    = term_q + 2'd1;
        if (term_q == 2'd3) begin
          grp_d = grp_q + 4'd1;
          if (grp_q == 4'd3) begin
            state_d = ST_MDRN;
            grp_d   = '0;
          end
        end
      end
      // wait for the last mounted component
      ST_MDRN: begin
        term_d = term_q + 2'd1;
        if (term_q == 2'd1) begin
          state_d = ST_CAPT;
          term_d  = '0;
        end
      end
      ST_CAPT: begin
        state_d = ST_REL;
        grp_d   = '0;
        term_d  = '0;
      end
      // rq = conj(start) * m
      ST_REL: begin
        iss.vld   = 1'b1;
        iss.first = (term_q == 2'd0);
        iss.last  = (term_q == 2'd3);
        iss.neg   = QUAT_NEG[{grp_q[1:0], term_q}] ^ (term_q != 2'd0);
        iss.dst   = DST_RQ;
        iss.idx   = grp_q;
        opa       = OPA_W'(start_ori_q[term_q]);
        opb       = OPB_W'(m_q[grp_q[1:0] ^ term_q]);
        term_d    = term_q + 2'd1;
        if (term_q == 2'd3) begin
          grp_d = grp_q + 4'd1;
          if (grp_q == 4'd3) begin
            state_d = ST_MAT;
            grp_d   = '0;
          end
        end
      end
      // rotation matrix of the start orientation, two products per entry
      ST_MAT: begin
        iss.vld   = 1'b1;
        iss.first = !term_q[0];
        iss.last  = term_q[0];
        iss.one   = mt.diag;
        iss.neg   = mt.neg;
        iss.dbl   = 1'b1;
        iss.dst   = DST_MAT;
        iss.idx   = grp_q;
        opa       = OPA_W'(start_ori_q[mt.ia]);
        opb       = OPB_W'(so_copy_q[mt.ib]);
        term_d    = {1'b0, !term_q[0]};
        if (term_q[0]) begin
          grp_d = grp_q + 4'd1;
          if (grp_q == 4'd8) begin
            state_d = ST_ROT;
            grp_d   = '0;
          end
        end
      end
      // rp = R^T * d
      ST_ROT: begin
        iss.vld   = 1'b1;
        iss.first = (term_q == 2'd0);
        iss.last  = (term_q == 2'd2);
        iss.dst   = DST_RP;
        iss.idx   = grp_q;
        opa       = mat_q[rot_idx];
        opb       = d_q[term_q];
        term_d    = term_q + 2'd1;
        if (term_q == 2'd2) begin
          term_d = '0;
          grp_d  = grp_q + 4'd1;
          if (grp_q == 4'd2) begin
            state_d = ST_RDRN;
            grp_d   = '0;
          end
        end
      end
      ST_RDRN: begin
        term_d = term_q + 2'd1;
        if (term_q == 2'd1) begin
          state_d = ST_OUT;
          term_d  = '0;
        end
      end
      // hand the result to the output register once it is free
      ST_OUT: begin
        if (!out_valid_q || pose_out_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control and start pose state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      grp_q          <= '0;
      term_q         <= '0;
      out_valid_q    <= 1'b0;
      pending_q      <= 1'b1;
      mount_q[0]     <= MOUNT_W_RST;
      mount_q[1]     <= MOUNT_X_RST;
      mount_q[2]     <= MOUNT_Y_RST;
      mount_q[3]     <= MOUNT_Z_RST;
      start_pos_q[0] <= '0;
      start_pos_q[1] <= '0;
      start_pos_q[2] <= '0;
      start_ori_q[0] <= Q_ONE;
      start_ori_q[1] <= '0;
      start_ori_q[2] <= '0;
      start_ori_q[3] <= '0;
    end else begin
      state_q <= state_d;
      grp_q   <= grp_d;
      term_q  <= term_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (pose_out_o.ready) out_valid_q <= 1'b0;
      if (cfg_i.valid) mount_q[cfg_i.data.index] <= cfg_i.data.value;
      if (in_acc && pose_in_i.data.set_start) pending_q <= 1'b1;
      if (state_q == ST_CAPT && cap) begin
        pending_q   <= 1'b0;
        start_pos_q <= pos_q;
        start_ori_q <= m_q;
      end
    end
  end

  // item payload, intermediate results and output register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q   <= pose_in_i.data.mode;
      pos_q[0] <= pose_in_i.data.in_pos_x;
      pos_q[1] <= pose_in_i.data.in_pos_y;
      pos_q[2] <= pose_in_i.data.in_pos_z;
      qin_q[0] <= pose_in_i.data.in_quat_w;
      qin_q[1] <= pose_in_i.data.in_quat_x;
      qin_q[2] <= pose_in_i.data.in_quat_y;
      qin_q[3] <= pose_in_i.data.in_quat_z;
    end
    // difference to the start, zero when this item becomes the start
    if (state_q == ST_CAPT) begin
      for (int k = 0; k < 3; k++) begin
        d_q[k] <= cap ? '0 : (D_W'(pos_q[k]) - D_W'(start_pos_q[k]));
      end
      so_copy_q <= cap ? m_q : start_ori_q;
    end
    if (wb.vld) begin
      case (wb.dst)
        DST_M:   m_q[wb.idx[1:0]]  <= sat_q(wb.value);
        DST_RQ:  rq_q[wb.idx[1:0]] <= sat_q(wb.value);
        DST_MAT: mat_q[wb.idx]     <= wb.value[MAT_W-1:0];
        DST_RP:  rp_q[wb.idx[1:0]] <= sat_p(wb.value);
        default: ;
      endcase
    end
    if (load_out) begin
      out_q.mounted_quat_w <= m_q[0];
      out_q.mounted_quat_x <= m_q[1];
      out_q.mounted_quat_y <= m_q[2];
      out_q.mounted_quat_z <= m_q[3];
      out_q.rel_pos_x      <= rp_q[0];
      out_q.rel_pos_y      <= rp_q[1];
      out_q.rel_pos_z      <= mode_q ? rp_q[2] : '0;
      out_q.rel_quat_w     <= rq_q[0];
      out_q.rel_quat_x     <= rq_q[1];
      out_q.rel_quat_y     <= rq_q[2];
      out_q.rel_quat_z     <= rq_q[3];
    end
  end

endmodule

[rtl/rpt_mac.sv]
// ----------------------------------------------------------------------------
// rpt_mac
// shared multiply-accumulate unit with round-half-up writeback
// ----------------------------------------------------------------------------
module rpt_mac import rpt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rpt_issue_t              iss_i,
  input  logic signed [OPA_W-1:0] opa_i,
  input  logic signed [OPB_W-1:0] opb_i,
  output rpt_wb_t                 wb_o
);

  localparam logic signed [ACC_W-1:0] MAT_ONE  = ACC_W'(2**28);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2**(FRAC_Q-1));

  logic signed [PROD_W-1:0] prod_q;
  rpt_issue_t               ctl_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  base, term, rnd_sum;
  logic                     wb_vld_q;
  rpt_dst_e                 wb_dst_q;
  logic [3:0]               wb_idx_q;

  // product stage
  always_ff @(posedge clk_i) begin
    prod_q <= opa_i * opb_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q    <= '0;
      wb_vld_q <= 1'b0;
    end else begin
      ctl_q    <= iss_i;
      wb_vld_q <= ctl_q.vld && ctl_q.last;
    end
  end

  // accumulate stage, a group starts from zero or from one in Q.28
  always_comb begin
    term = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    if (ctl_q.dbl) term = term <<< 1;
    if (ctl_q.first) base = ctl_q.one ? MAT_ONE : '0;
    else base = acc_q;
    acc_d = ctl_q.neg ? (base - term) : (base + term);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_q.vld) acc_q <= acc_d;
    if (ctl_q.vld && ctl_q.last) begin
      wb_dst_q <= ctl_q.dst;
      wb_idx_q <= ctl_q.idx;
    end
  end

  // round half up: floor((acc + 2^13) / 2^14)
  assign rnd_sum = acc_q + RND_HALF;

  always_comb begin
    wb_o.vld   = wb_vld_q;
    wb_o.dst   = wb_dst_q;
    wb_o.idx   = wb_idx_q;
    wb_o.value = rnd_sum[ACC_W-1:FRAC_Q];
  end

endmodule

[rtl/rpt_checker.sv]
// ----------------------------------------------------------------------------
// rpt_checker
// port-level checks of the relative pose transform, bound to the top level
// ----------------------------------------------------------------------------
`include "relative_pose_transform_top_macros.svh"

module rpt_checker import rpt_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input rpt_out_t out_data_i
);

  logic [1:0] open_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // items accepted and not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_acc && !out_acc) begin
      open_q <= open_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      open_q <= open_q - 2'd1;
    end
  end

  `RPT_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")
  `RPT_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_data_i), "result changed")
  `RPT_ASSERT_NEXT(a_busy_after_in, in_acc, !in_ready_i, "item taken while busy")
  `RPT_ASSERT(a_no_phantom, $rose(out_valid_i) |-> (open_q != 2'd0), "result without item")

endmodule

bind relative_pose_transform_top rpt_checker u_rpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pose_in_i.valid),
  .in_ready_i  (pose_in_i.ready),
  .out_valid_i (pose_out_o.valid),
  .out_ready_i (pose_out_o.ready),
  .out_data_i  (pose_out_o.data)
);

[bench/rpt_pose_checker.sv]
// ----------------------------------------------------------------------------
// rpt_pose_checker
// watches the pose, result and mount channels of the relative pose block,
// predicts every result item from its own copy of the mount and start pose,
// and compares each result field by field in arrival order
// ----------------------------------------------------------------------------
package rpt_tb_pkg;
  import rpt_pkg::*;

  // item kinds carried in the mode field
  localparam logic MODE_ODOM = 1'b0;
  localparam logic MODE_PATH = 1'b1;

  // mount register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOUNT_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOUNT_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOUNT_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOUNT_Z = 2'd3;

  // quaternion held at full precision for the predictor
  typedef struct {
    longint w;
    longint x;
    longint y;
    longint z;
  } quat_t;
endpackage

module rpt_pose_checker
  import rpt_pkg::*;
  import rpt_tb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     pose_valid_i,
  input  logic     pose_ready_i,
  input  rpt_in_t  pose_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  rpt_out_t out_data_i,
  input  logic     cfg_valid_i,
  input  logic     cfg_ready_i,
  input  rpt_cfg_t cfg_data_i,
  output int       fail_count_o,
  output int       pending_o,
  output int       checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // predictor state
  logic signed [Q_W-1:0] mount_reg [4];
  longint                start_pos [3];
  quat_t                 start_ori;
  bit                    capture_armed;
  rpt_out_t              relative_pose_q [$];

  // floor((v + 2^13) / 2^14)
  function automatic longint round_q14(input longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // hamilton product, rounded and saturated to q2.14
  function automatic quat_t quat_mul(input quat_t a, input quat_t b);
    quat_t r;
    r.w = clamp(round_q14(a.w*b.w - a.x*b.x - a.y*b.y - a.z*b.z), Q_W);
    r.x = clamp(round_q14(a.w*b.x + a.x*b.w + a.y*b.z - a.z*b.y), Q_W);
    r.y = clamp(round_q14(a.w*b.y - a.x*b.z + a.y*b.w + a.z*b.x), Q_W);
    r.z = clamp(round_q14(a.w*b.z + a.x*b.y - a.y*b.x + a.z*b.w), Q_W);
    return r;
  endfunction

  // one pose item in, one result item out; may capture the start pose
  function automatic rpt_out_t transform_pose(input rpt_in_t item);
    quat_t    body;
    quat_t    mnt;
    quat_t    mounted;
    quat_t    conj;
    quat_t    rel;
    longint   pos [3];
    longint   d [3];
    longint   rot [3][3];
    longint   rp [3];
    longint   w, x, y, z, one;
    rpt_out_t r;
    one    = 64'sd1 <<< 28;
    body.w = $signed(item.in_quat_w);
    body.x = $signed(item.in_quat_x);
    body.y = $signed(item.in_quat_y);
    body.z = $signed(item.in_quat_z);
    pos[0] = $signed(item.in_pos_x);
    pos[1] = $signed(item.in_pos_y);
    pos[2] = $signed(item.in_pos_z);
    mnt.w  = mount_reg[REG_MOUNT_W];
    mnt.x  = mount_reg[REG_MOUNT_X];
    mnt.y  = mount_reg[REG_MOUNT_Y];
    mnt.z  = mount_reg[REG_MOUNT_Z];

    // a start request arms the capture before this item is used
    if (item.set_start) capture_armed = 1'b1;
    mounted = quat_mul(body, mnt);
    if (item.mode == MODE_ODOM && capture_armed) begin
      for (int i = 0; i < 3; i++) start_pos[i] = pos[i];
      start_ori     = mounted;
      capture_armed = 1'b0;
    end

    // relative orientation through the conjugate of the start
    w = start_ori.w;
    x = start_ori.x;
    y = start_ori.y;
    z = start_ori.z;
    conj.w = w;
    conj.x = -x;
    conj.y = -y;
    conj.z = -z;
    rel = quat_mul(conj, mounted);

    // rotation matrix of the start, entries rounded to q.14
    rot[0][0] = round_q14(one - 2*(y*y + z*z));
    rot[0][1] = round_q14(2*(x*y - w*z));
    rot[0][2] = round_q14(2*(x*z + w*y));
    rot[1][0] = round_q14(2*(x*y + w*z));
    rot[1][1] = round_q14(one - 2*(x*x + z*z));
    rot[1][2] = round_q14(2*(y*z - w*x));
    rot[2][0] = round_q14(2*(x*z - w*y));
    rot[2][1] = round_q14(2*(y*z + w*x));
    rot[2][2] = round_q14(one - 2*(x*x + y*y));

    // transposed rotation applied to the exact offset
    for (int i = 0; i < 3; i++) d[i] = pos[i] - start_pos[i];
    for (int i = 0; i < 3; i++) begin
      rp[i] = clamp(round_q14(rot[0][i]*d[0] + rot[1][i]*d[1] + rot[2][i]*d[2]), P_W);
    end
    if (item.mode == MODE_ODOM) rp[2] = 0;

    r.mounted_quat_w = mounted.w[Q_W-1:0];
    r.mounted_quat_x = mounted.x[Q_W-1:0];
    r.mounted_quat_y = mounted.y[Q_W-1:0];
    r.mounted_quat_z = mounted.z[Q_W-1:0];
    r.rel_pos_x      = rp[0][P_W-1:0];
    r.rel_pos_y      = rp[1][P_W-1:0];
    r.rel_pos_z      = rp[2][P_W-1:0];
    r.rel_quat_w     = rel.w[Q_W-1:0];
    r.rel_quat_x     = rel.x[Q_W-1:0];
    r.rel_quat_y     = rel.y[Q_W-1:0];
    r.rel_quat_z     = rel.z[Q_W-1:0];
    return r;
  endfunction

  // one line per mismatch, and count it
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d field %s got %0d want %0d",
                                checked_o, name, got, want));
    end
  endtask

  // results first, then mount writes, then new pose items
  always @(posedge clk_i or negedge rst_ni) begin : watch
    rpt_out_t want;
    if (!rst_ni) begin
      mount_reg[REG_MOUNT_W] = MOUNT_W_RST;
      mount_reg[REG_MOUNT_X] = MOUNT_X_RST;
      mount_reg[REG_MOUNT_Y] = MOUNT_Y_RST;
      mount_reg[REG_MOUNT_Z] = MOUNT_Z_RST;
      for (int i = 0; i < 3; i++) start_pos[i] = 0;
      start_ori.w   = Q_ONE;
      start_ori.x   = 0;
      start_ori.y   = 0;
      start_ori.z   = 0;
      capture_armed = 1'b1;
      relative_pose_q.delete();
      fail_count_o  = 0;
      checked_o     = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (relative_pose_q.size() == 0) begin
          report_mismatch("result item with no pose item outstanding");
        end else begin
          want = relative_pose_q.pop_front();
          check_field("mounted_quat_w", $signed(out_data_i.mounted_quat_w),
                      $signed(want.mounted_quat_w));
          check_field("mounted_quat_x", $signed(out_data_i.mounted_quat_x),
                      $signed(want.mounted_quat_x));
          check_field("mounted_quat_y", $signed(out_data_i.mounted_quat_y),
                      $signed(want.mounted_quat_y));
          check_field("mounted_quat_z", $signed(out_data_i.mounted_quat_z),
                      $signed(want.mounted_quat_z));
          check_field("rel_pos_x", $signed(out_data_i.rel_pos_x), $signed(want.rel_pos_x));
          check_field("rel_pos_y", $signed(out_data_i.rel_pos_y), $signed(want.rel_pos_y));
          check_field("rel_pos_z", $signed(out_data_i.rel_pos_z), $signed(want.rel_pos_z));
          check_field("rel_quat_w", $signed(out_data_i.rel_quat_w), $signed(want.rel_quat_w));
          check_field("rel_quat_x", $signed(out_data_i.rel_quat_x), $signed(want.rel_quat_x));
          check_field("rel_quat_y", $signed(out_data_i.rel_quat_y), $signed(want.rel_quat_y));
          check_field("rel_quat_z", $signed(out_data_i.rel_quat_z), $signed(want.rel_quat_z));
        end
        checked_o++;
      end
      if (cfg_valid_i && cfg_ready_i) mount_reg[cfg_data_i.index] = cfg_data_i.value;
      if (pose_valid_i && pose_ready_i) begin
        relative_pose_q = {relative_pose_q, transform_pose(pose_data_i)};
      end
    end
    pending_o = relative_pose_q.size();
  end

endmodule

[bench/relative_pose_transform_top_tb.sv]
// ----------------------------------------------------------------------------
// relative_pose_transform_top_tb
// drives pose items and mount writes into the relative pose block: a directed
// run of capture, path, saturation and axis-rotation cases under the reset mount,
// then random poses under several mount settings, idling at random on both
// channels in all but one; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module relative_pose_transform_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rpt_pkg::*;
  import rpt_tb_pkg::*;

  localparam int ITEMS_PER_SETTING = 86;
  localparam int NUM_SETTINGS      = 7;
  localparam int QUIET_SETTING     = 2;
  localparam int DRAIN_CYCLES      = 70;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bit pace_on = 1'b1;
  int fail_cnt;
  int pending_cnt;
  int checked_cnt;
  int odom_sent;
  int path_sent;
  int settings_used;

  rpt_chan_if #(.T(rpt_in_t))  pose_in_if ();
  rpt_chan_if #(.T(rpt_out_t)) pose_out_if ();
  rpt_chan_if #(.T(rpt_cfg_t)) cfg_if ();

  relative_pose_transform_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pose_in_i  (pose_in_if),
    .pose_out_o (pose_out_if),
    .cfg_i      (cfg_if)
  );

  rpt_pose_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pose_valid_i (pose_in_if.valid),
    .pose_ready_i (pose_in_if.ready),
    .pose_data_i  (pose_in_if.data),
    .out_valid_i  (pose_out_if.valid),
    .out_ready_i  (pose_out_if.ready),
    .out_data_i   (pose_out_if.data),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_ready_i  (cfg_if.ready),
    .cfg_data_i   (cfg_if.data),
    .fail_count_o (fail_cnt),
    .pending_o    (pending_cnt),
    .checked_o    (checked_cnt)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side stalls at random, one time in ten, while pacing is on
  initial begin
    pose_out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      pose_out_if.ready <= pace_on ? ($urandom_range(99) >= 10) : 1'b1;
    end
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("timed out with %0d result items outstanding", pending_cnt);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [P_W-1:0] pos_extreme();
    case ($urandom_range(3))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      default: return 32'h0000_0000;
    endcase
  endfunction

  function automatic logic [Q_W-1:0] quat_extreme();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h4000;
      3:       return 16'hc000;
      default: return 16'h0000;
    endcase
  endfunction

  // hold the item until accepted, with random idle cycles ahead of it while pacing is on
  task automatic drive_pose(input rpt_in_t item);
    while (pace_on && $urandom_range(99) < 10) begin
      pose_in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pose_in_if.valid <= 1'b1;
    pose_in_if.data  <= item;
    @(posedge clk_i);
    while (!pose_in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (item.mode == MODE_ODOM) odom_sent++;
    else path_sent++;
  endtask

  task automatic send_pose(input logic mode, input logic set_start,
                           input logic [P_W-1:0] px, input logic [P_W-1:0] py,
                           input logic [P_W-1:0] pz, input logic [Q_W-1:0] qw,
                           input logic [Q_W-1:0] qx, input logic [Q_W-1:0] qy,
                           input logic [Q_W-1:0] qz);
    rpt_in_t item;
    item.mode      = mode;
    item.set_start = set_start;
    item.in_pos_x  = px;
    item.in_pos_y  = py;
    item.in_pos_z  = pz;
    item.in_quat_w = qw;
    item.in_quat_x = qx;
    item.in_quat_y = qy;
    item.in_quat_z = qz;
    drive_pose(item);
  endtask

  // sender holds off until every result item has come back
  task automatic drain_results();
    pose_in_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
  endtask

  // mount writes only once the block has gone quiet
  task automatic set_mount(input logic [Q_W-1:0] w, input logic [Q_W-1:0] x,
                           input logic [Q_W-1:0] y, input logic [Q_W-1:0] z);
    logic [Q_W-1:0]       vals [4];
    logic [CFG_IDX_W-1:0] regs [4];
    vals = '{w, x, y, z};
    regs = '{REG_MOUNT_W, REG_MOUNT_X, REG_MOUNT_Y, REG_MOUNT_Z};
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.data  <= '{index: regs[i], value: vals[i]};
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      @(negedge clk_i);
    end
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    rpt_in_t item;
    int      kind;
    pose_in_if.valid = 1'b0;
    pose_in_if.data  = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    odom_sent        = 0;
    path_sent        = 0;
    settings_used    = 1;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // before any capture the start is identity at the origin
    send_pose(MODE_PATH, 1'b0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
              16'h4000, 16'h0000, 16'h0000, 16'h0000);
    // path item never captures, even with a request
    send_pose(MODE_PATH, 1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    // first odometry item takes the pending capture
    send_pose(MODE_ODOM, 1'b0, 32'h000a_0000, 32'hfffb_0000, 32'h0002_0000,
              16'h4000, 16'h0000, 16'h0000, 16'h0000);
    // odometry against the start, z forced to zero
    send_pose(MODE_ODOM, 1'b0, 32'h000c_8000, 32'hfff0_0000, 32'h0005_0000,
              16'h2d41, 16'h2d41, 16'h0000, 16'h0000);
    send_pose(MODE_PATH, 1'b0, 32'h000c_8000, 32'hfff0_0000, 32'h0005_0000,
              16'h2d41, 16'h0000, 16'h2d41, 16'h0000);
    // odometry with a request captures itself
    send_pose(MODE_ODOM, 1'b1, 32'hffff_0000, 32'h0001_0000, 32'h0000_8000,
              16'h2d41, 16'h0000, 16'h0000, 16'h2d41);
    drain_results();
    // field extremes and saturation
    send_pose(MODE_PATH, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_pose(MODE_ODOM, 1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_pose(MODE_PATH, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
              16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pose(MODE_PATH, 1'b0, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff,
              16'hffff, 16'h0001, 16'hffff, 16'h0001);
    // capture of a non-unit start blows up the rotation
    send_pose(MODE_ODOM, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
              16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_pose(MODE_PATH, 1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              16'h4000, 16'h0000, 16'h0000, 16'h0000);
    send_pose(MODE_PATH, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              16'h0000, 16'h4000, 16'h0000, 16'h0000);
    send_pose(MODE_ODOM, 1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              16'h0000, 16'h0000, 16'h4000, 16'h0000);
    // zero start orientation
    send_pose(MODE_ODOM, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
              16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pose(MODE_PATH, 1'b0, 32'h0010_0000, 32'hfff0_0000, 32'h0010_0000,
              16'h0000, 16'h0000, 16'h0000, 16'h4000);
    // back to a unit start, axis rotations
    send_pose(MODE_ODOM, 1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
              16'h2d41, 16'hd2bf, 16'h0000, 16'h0000);
    send_pose(MODE_PATH, 1'b0, 32'h0004_0000, 32'h0005_0000, 32'h0006_0000,
              16'hc000, 16'h0000, 16'h0000, 16'h0000);
    send_pose(MODE_PATH, 1'b0, 32'hfffc_0000, 32'h0005_0000, 32'hfffa_0000,
              16'h0000, 16'h0000, 16'hc000, 16'h0000);
    send_pose(MODE_ODOM, 1'b0, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001,
              16'h2000, 16'h2000, 16'h2000, 16'he000);

    // random poses under a range of mount settings
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      pace_on = 1'b1;
      case (s)
        0:       set_mount(16'h4000, 16'h0000, 16'h0000, 16'h0000);
        1:       set_mount(16'h4000, 16'h4000, 16'h4000, 16'h4000);
        2:       set_mount(16'hc000, 16'hc000, 16'hc000, 16'hc000);
        3:       set_mount(16'h4000, 16'hc000, 16'hc000, 16'h4000);
        4:       set_mount(16'h2000, 16'h2000, 16'h2000, 16'he000);
        default: set_mount(Q_W'($urandom_range(32768) - 16384),
                           Q_W'($urandom_range(32768) - 16384),
                           Q_W'($urandom_range(32768) - 16384),
                           Q_W'($urandom_range(32768) - 16384));
      endcase
      pace_on = (s != QUIET_SETTING);
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        kind           = $urandom_range(99);
        item.mode      = ($urandom_range(99) < 30) ? MODE_PATH : MODE_ODOM;
        item.set_start = ($urandom_range(99) < 6);
        if (kind < 65) begin
          // plausible pose: a few hundred metres, components within one
          item.in_pos_x  = $urandom_range(33554431) - 32'd16777216;
          item.in_pos_y  = $urandom_range(33554431) - 32'd16777216;
          item.in_pos_z  = $urandom_range(33554431) - 32'd16777216;
          item.in_quat_w = Q_W'($urandom_range(32768) - 16384);
          item.in_quat_x = Q_W'($urandom_range(32768) - 16384);
          item.in_quat_y = Q_W'($urandom_range(32768) - 16384);
          item.in_quat_z = Q_W'($urandom_range(32768) - 16384);
        end else if (kind < 90) begin
          item.in_pos_x  = $urandom();
          item.in_pos_y  = $urandom();
          item.in_pos_z  = $urandom();
          item.in_quat_w = Q_W'($urandom());
          item.in_quat_x = Q_W'($urandom());
          item.in_quat_y = Q_W'($urandom());
          item.in_quat_z = Q_W'($urandom());
        end else begin
          item.in_pos_x  = pos_extreme();
          item.in_pos_y  = pos_extreme();
          item.in_pos_z  = pos_extreme();
          item.in_quat_w = quat_extreme();
          item.in_quat_x = quat_extreme();
          item.in_quat_y = quat_extreme();
          item.in_quat_z = quat_extreme();
        end
        drive_pose(item);
        if ($urandom_range(99) < 2) drain_results();
      end
    end

    // wrap up
    pose_in_if.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("covered %0d odometry and %0d path items under %0d mount settings",
             odom_sent, path_sent, settings_used);
    $display("%0d result items checked, idling on both channels except one setting",
             checked_cnt);
    if (fail_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
